// File: sv/isort_pkg.sv
// isort_pkg: shared widths and defaults for the insertion sorter.
// No dependencies; imported by insertion_sorter, isort_checker and tb_insertion_sorter.
package isort_pkg;

  // Width of one element of the set
  localparam int unsigned DATA_W = 32;

  // Default number of stored elements
  localparam int unsigned CAPACITY_DEF = 16;

endpackage : isort_pkg

// File: sv/insertion_sorter.sv
// insertion_sorter: sorts a set of signed values into ascending order.
// Depends on isort_pkg for widths and the default capacity.
//
// Usage: present one element per transaction on the input channel
// (in_valid_i / in_stall_o); raise last_item_i on the final element of a set.
// Each element is inserted into an internal store by one shared compare
// unit that walks the store from the top, one compare-and-move per cycle.
// Equal values keep their order of arrival. in_stall_o is high while an
// insertion or an emission runs.
// Elements that arrive while the store is full are dropped, and every
// result of that set has overflow_o set.
// After the last element the store is read out through one registered
// read port: a priming state, then one result per cycle on the output
// channel (out_valid_o / out_stall_i) while the receiver does not stall.
// last_result_o marks the final result. A stall holds the output register
// and pauses the read-out. The next set may start while the final result
// still waits in the output register.
// Reset empties the store (the count is cleared; contents are not) and
// drops any pending result.
module insertion_sorter #(
  parameter int unsigned CAPACITY = isort_pkg::CAPACITY_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic signed [isort_pkg::DATA_W-1:0] value_i,
  input  logic                                last_item_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [isort_pkg::DATA_W-1:0] sorted_value_o,
  output logic                                last_result_o,
  output logic                                overflow_o
);
  import isort_pkg::*;

  localparam int unsigned ADDR_W = $clog2(CAPACITY);
  localparam int unsigned CNT_W  = $clog2(CAPACITY + 1);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CMP   = 5'b00010,
    S_PLACE = 5'b00100,
    S_PRIME = 5'b01000,
    S_EMIT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [CNT_W-1:0]  count_q, count_d;
  logic              ovf_q, ovf_d;
  logic [ADDR_W-1:0] pos_q, pos_d;
  logic signed [DATA_W-1:0] val_q, val_d;
  logic              last_q, last_d;

  // Store and its single read/write ports
  logic signed [DATA_W-1:0] store_mem [CAPACITY];
  logic signed [DATA_W-1:0] rdata_q;
  logic [ADDR_W-1:0] rd_addr;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic signed [DATA_W-1:0] wr_data;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic signed [DATA_W-1:0] out_value_q, out_value_d;
  logic              out_last_q, out_last_d;
  logic              out_ovf_q, out_ovf_d;

  logic in_accept;
  logic out_free;
  logic is_larger;
  logic emit_last;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && (state_q == S_IDLE);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign is_larger  = (rdata_q > val_q);
  assign emit_last  = ((CNT_W'(pos_q) + CNT_W'(1)) == count_q);

  // Sequencer: insert, then read out on a last element
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    ovf_d       = ovf_q;
    pos_d       = pos_q;
    val_d       = val_q;
    last_d      = last_q;
    rd_addr     = pos_q;
    wr_en       = 1'b0;
    wr_addr     = pos_q;
    wr_data     = val_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_value_d = out_value_q;
    out_last_d  = out_last_q;
    out_ovf_d   = out_ovf_q;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          val_d  = value_i;
          last_d = last_item_i;
          if (count_q < CNT_W'(CAPACITY)) begin
            pos_d   = count_q[ADDR_W-1:0];
            rd_addr = ADDR_W'(count_q - CNT_W'(1));
            state_d = (count_q == '0) ? S_PLACE : S_CMP;
          end else begin
            ovf_d = 1'b1;
            pos_d = '0;
            if (last_item_i) begin
              state_d = S_PRIME;
            end
          end
        end
      end

      S_CMP: begin
        if (is_larger) begin
          // Move the larger neighbor up one place
          wr_en   = 1'b1;
          wr_addr = pos_q;
          wr_data = rdata_q;
          pos_d   = pos_q - ADDR_W'(1);
          rd_addr = pos_q - ADDR_W'(2);
          if (pos_q == ADDR_W'(1)) begin
            state_d = S_PLACE;
          end
        end else begin
          // Drop the new value into the gap
          wr_en   = 1'b1;
          wr_addr = pos_q;
          wr_data = val_q;
          count_d = count_q + CNT_W'(1);
          pos_d   = '0;
          state_d = last_q ? S_PRIME : S_IDLE;
        end
      end

      S_PLACE: begin
        wr_en   = 1'b1;
        wr_addr = pos_q;
        wr_data = val_q;
        count_d = count_q + CNT_W'(1);
        pos_d   = '0;
        state_d = last_q ? S_PRIME : S_IDLE;
      end

      S_PRIME: begin
        rd_addr = pos_q;
        state_d = S_EMIT;
      end

      S_EMIT: begin
        rd_addr = pos_q;
        if (out_free) begin
          out_valid_d = 1'b1;
          out_value_d = rdata_q;
          out_last_d  = emit_last;
          out_ovf_d   = ovf_q;
          if (emit_last) begin
            count_d = '0;
            ovf_d   = 1'b0;
            pos_d   = '0;
            state_d = S_IDLE;
          end else begin
            pos_d   = pos_q + ADDR_W'(1);
            rd_addr = pos_q + ADDR_W'(1);
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      ovf_q       <= 1'b0;
      pos_q       <= '0;
      last_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      ovf_q       <= ovf_d;
      pos_q       <= pos_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    val_q       <= val_d;
    out_value_q <= out_value_d;
    out_last_q  <= out_last_d;
    out_ovf_q   <= out_ovf_d;
  end

  // Store write port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
  end

  // Store registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= store_mem[rd_addr];
  end

  assign out_valid_o    = out_valid_q;
  assign sorted_value_o = out_value_q;
  assign last_result_o  = out_last_q;
  assign overflow_o     = out_ovf_q;

endmodule : insertion_sorter

// File: sv/isort_checker.sv
// isort_checker: port-level checks for insertion_sorter, bound to every instance.
// Depends on isort_pkg and on the insertion_sorter port list.
module isort_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [isort_pkg::DATA_W-1:0] sorted_value_o,
  input logic                                last_result_o,
  input logic                                overflow_o
);
  import isort_pkg::*;

  logic                     out_acc;
  logic                     in_set_q;
  logic signed [DATA_W-1:0] prev_value_q;
  logic                     prev_ovf_q;

  assign out_acc = out_valid_o && !out_stall_i;

  // Track the previous result transaction within one set
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_set_q     <= 1'b0;
      prev_value_q <= '0;
      prev_ovf_q   <= 1'b0;
    end else if (out_acc) begin
      in_set_q     <= !last_result_o;
      prev_value_q <= sorted_value_o;
      prev_ovf_q   <= overflow_o;
    end
  end

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sorted_value_o)
      && $stable(last_result_o) && $stable(overflow_o))
    else $error("stalled result changed");

  // Results of one set come out in ascending order
  a_ascending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && in_set_q |-> sorted_value_o >= prev_value_q)
    else $error("results out of order");

  // The overflow flag is the same on every result of a set
  a_ovf_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && in_set_q |-> overflow_o == prev_ovf_q)
    else $error("overflow flag changed within a set");

  // No new input is taken while a set is still being read out
  a_busy_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_result_o |-> in_stall_o)
    else $error("input taken during read-out");

endmodule : isort_checker

bind insertion_sorter isort_checker u_isort_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .sorted_value_o (sorted_value_o),
  .last_result_o  (last_result_o),
  .overflow_o     (overflow_o)
);

// File: sim/tb_insertion_sorter.sv
// tb_insertion_sorter: self-checking testbench for the insertion sorter.
// Depends on isort_pkg and insertion_sorter; drives sets of signed values
// and checks each result against a behavioral model of the store or a typed row's result.
module tb_insertion_sorter;
  timeunit 1ns;
  timeprecision 1ps;

  import isort_pkg::*;

  localparam int unsigned CAP = CAPACITY_DEF;
  localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam int PHASE_ITEMS  = 85;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 2 * CAP + 20;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DIR_ROWS     = 8;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic                     last;
    logic                     ovf;
  } sorted_res_t;

  // One row of the directed table: n values starting at first, spaced by step
  typedef struct packed {
    logic signed [DATA_W-1:0] first;
    logic signed [7:0]        step;
    logic [7:0]               n;
    logic                     last;
    logic                     typed;
    sorted_res_t              res;
  } dir_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [DATA_W-1:0] value;
  logic                     last_item;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] sorted_value;
  logic                     last_result;
  logic                     overflow;

  // Model of the sorter state
  logic signed [DATA_W-1:0] sorted_list [CAP];
  int                       list_count;
  logic                     list_ovf;
  sorted_res_t              pending_sorted_q [$];

  // Sender-side controls, seen by the monitor at acceptance
  logic                     typed_live;
  sorted_res_t              typed_res;
  int                       send_idle_pct;
  int                       rx_stall_pct;
  logic                     hold_req;

  int                       errors;
  int                       cycles;
  int                       items_sent;
  int                       sets_done;
  int                       ovf_sets;
  int                       results_checked;

  dir_row_t                 dir_rows [DIR_ROWS];

  insertion_sorter i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .value_i        (value),
    .last_item_i    (last_item),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .sorted_value_o (sorted_value),
    .last_result_o  (last_result),
    .overflow_o     (overflow)
  );

  // Generate the 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Insert one accepted value; on the last item queue the whole sorted set
  task automatic insert_and_flush(input logic signed [DATA_W-1:0] v, input logic l);
    int j;
    int k;
    if (list_count < CAP) begin
      j = list_count;
      while (j > 0 && sorted_list[j-1] > v) begin
        sorted_list[j] = sorted_list[j-1];
        j--;
      end
      sorted_list[j] = v;
      list_count++;
    end else begin
      list_ovf = 1'b1;
    end
    if (l) begin
      sets_done++;
      if (list_ovf) ovf_sets++;
      if (typed_live) begin
        pending_sorted_q.push_back(typed_res);
      end else begin
        for (k = 0; k < list_count; k++) begin
          pending_sorted_q.push_back('{sorted_list[k], (k == list_count - 1), list_ovf});
        end
      end
      list_count = 0;
      list_ovf   = 1'b0;
    end
  endtask

  // Watch both channels at the rising edge
  always @(posedge clk) begin
    sorted_res_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) insert_and_flush(value, last_item);
      if (out_valid && !out_stall) begin
        results_checked++;
        if (pending_sorted_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result value %0d last %0b overflow %0b",
                   $time, sorted_value, last_result, overflow);
        end else begin
          want = pending_sorted_q.pop_front();
          if (sorted_value !== want.value) begin
            errors++;
            $display("%0t: sorted_value expected %0d got %0d", $time, want.value, sorted_value);
          end
          if (last_result !== want.last) begin
            errors++;
            $display("%0t: last_result expected %0b got %0b", $time, want.last, last_result);
          end
          if (overflow !== want.ovf) begin
            errors++;
            $display("%0t: overflow expected %0b got %0b", $time, want.ovf, overflow);
          end
        end
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_sorted_q.size());
      $display("insertion_sorter regression: fail");
      $finish;
    end
  end

  // Receiver: random stall, or a long hold-off on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  // Offer one transaction after a random gap and hold it until accepted
  task automatic send_item(input logic signed [DATA_W-1:0] v, input logic l,
                           input logic typed, input sorted_res_t tres);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    value      <= v;
    last_item  <= l;
    typed_live = typed;
    typed_res  = tres;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // Send one set with mixed extremes, small clustered values and full-range values
  task automatic send_random_set(input int forced_n);
    int n;
    int k;
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(9))
      0:       n = $urandom_range(CAP + 1, CAP + 4);
      1:       n = 1;
      default: n = $urandom_range(2, CAP);
    endcase
    if (forced_n > 0) n = forced_n;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0: begin
          case ($urandom_range(3))
            0:       v = VAL_MAX;
            1:       v = VAL_MIN;
            2:       v = '0;
            default: v = '1;
          endcase
        end
        1, 2, 3: v = $urandom_range(16) - 8;
        default: v = $urandom;
      endcase
      send_item(v, (k == n - 1), 1'b0, '0);
    end
  endtask

  // Hold the input idle until every queued result has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_sorted_q.size() != 0) @(negedge clk);
  endtask

  initial begin
    int r;
    int k;
    int ph;
    int start;
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    value           = '0;
    last_item       = 1'b0;
    typed_live      = 1'b0;
    typed_res       = '0;
    send_idle_pct   = 0;
    rx_stall_pct    = 0;
    hold_req        = 1'b0;
    errors          = 0;
    cycles          = 0;
    items_sent      = 0;
    sets_done       = 0;
    ovf_sets        = 0;
    results_checked = 0;
    list_count      = 0;
    list_ovf        = 1'b0;

    // Directed table: single extremes, a small mixed set, equal values,
    // a full store in reverse order, then a last item dropped while full
    dir_rows[0] = '{VAL_MAX, 8'sd0,  8'd1,  1'b1, 1'b1, '{VAL_MAX, 1'b1, 1'b0}};
    dir_rows[1] = '{VAL_MIN, 8'sd0,  8'd1,  1'b1, 1'b1, '{VAL_MIN, 1'b1, 1'b0}};
    dir_rows[2] = '{32'sd0,  8'sd0,  8'd1,  1'b0, 1'b0, '0};
    dir_rows[3] = '{-32'sd1, 8'sd0,  8'd1,  1'b0, 1'b0, '0};
    dir_rows[4] = '{32'sd1,  8'sd0,  8'd1,  1'b1, 1'b0, '0};
    dir_rows[5] = '{32'sd7,  8'sd0,  8'd3,  1'b1, 1'b0, '0};
    dir_rows[6] = '{32'sd15, -8'sd1, 8'd16, 1'b0, 1'b0, '0};
    dir_rows[7] = '{VAL_MIN, 8'sd0,  8'd1,  1'b1, 1'b0, '0};

    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Walk the directed table
    for (r = 0; r < DIR_ROWS; r++) begin
      for (k = 0; k < dir_rows[r].n; k++) begin
        send_item(dir_rows[r].first + dir_rows[r].step * k,
                  dir_rows[r].last && (k == dir_rows[r].n - 1),
                  dir_rows[r].typed, dir_rows[r].res);
      end
    end
    wait_drained();

    // Random sets under each idling pattern, pausing between phases
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin send_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin send_idle_pct = 82; rx_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  rx_stall_pct = 82; end
        default: begin send_idle_pct = 19; rx_stall_pct = 19; end
      endcase
      start = items_sent;
      while (items_sent - start < PHASE_ITEMS) send_random_set(0);
      wait_drained();
    end

    // Back-pressure: receiver holds off while an overfull set and more arrive
    send_idle_pct = 0;
    rx_stall_pct  = 0;
    hold_req      = 1'b1;
    send_random_set(CAP + 4);
    send_random_set(5);
    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d items in %0d sets (%0d with dropped items), checked %0d results,",
             items_sent, sets_done, ovf_sets, results_checked);
    $display("across free-running, sender-idle, receiver-stall, mixed and hold-off phases.");
    if (errors == 0 && pending_sorted_q.size() == 0) begin
      $display("insertion_sorter regression: pass");
    end else begin
      $display("insertion_sorter regression: fail");
    end
    $finish;
  end

endmodule : tb_insertion_sorter

// File: sim.f
sv/isort_pkg.sv
sv/insertion_sorter.sv
sv/isort_checker.sv
sim/tb_insertion_sorter.sv
